// ----- hw/rtl/bfik_pkg.sv -----
// ----------------------------------------------------------------------------
// bfik_pkg: shared definitions for the bloom filter
// Constants, configuration codes, queue entry and state machine types.
// ----------------------------------------------------------------------------
package bfik_pkg;

  localparam int LOG2_MAX_BITS_DEF = 16;
  localparam int MAX_HASHES_DEF    = 16;

  localparam int WORD_BITS  = 32;
  localparam int BIT_SEL_W  = $clog2(WORD_BITS);
  localparam int KEY_W      = 64;
  localparam int HALF_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int CFG_W      = 5;
  localparam int CFG_IDX_W  = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  localparam logic [KEY_W-1:0] HASH_XOR_CONST = 64'ha0761d6478bd642f;
  localparam logic [KEY_W-1:0] HASH_MUL_CONST = 64'he7037ed1a0b428db;

  localparam logic [CFG_W-1:0] NUM_HASHES_RST = 5'd3;
  localparam logic [CFG_W-1:0] LOG2_BITS_RST  = 5'd16;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TEST   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_HASHES = 2'd0,
    CFG_LOG2_BITS  = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] num_hashes;
    logic [CFG_W-1:0] log2_bits_used;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [HALF_W-1:0] h1;
    logic [HALF_W-1:0] h2;
  } hash_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CHECK,
    B_DONE
  } back_state_t;

endpackage

// ----- hw/rtl/bfik_if.sv -----
// ----------------------------------------------------------------------------
// bfik_if: request and result channels
// Valid/ready channels carrying key requests and filter results.
// ----------------------------------------------------------------------------
interface bfik_req_if import bfik_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink (input valid, input mode, input key, output ready);
endinterface

interface bfik_rsp_if import bfik_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               present;
  logic [COUNT_W-1:0] inserted_total;

  modport source (output valid, output present, output inserted_total, input ready);
  modport sink (input valid, input present, input inserted_total, output ready);
endinterface

// ----- hw/rtl/bfik_ram.sv -----
// ----------------------------------------------------------------------------
// bfik_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bfik_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/bfik_front.sv -----
// ----------------------------------------------------------------------------
// bfik_front: request intake and key hashing
// Takes a request, forms the 128-bit product from four 32x32 partial
// products on one shared multiplier, folds it and queues h1, h2 and mode.
// ----------------------------------------------------------------------------
module bfik_front import bfik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        clearing,
  bfik_req_if.sink    request,
  output logic        push,
  output hash_entry_t push_data,
  input  logic        full
);

  front_state_t           state;
  front_state_t           state_next;
  logic [2:0]             cnt;
  logic                   mode_r;
  logic [KEY_W-1:0]       a;
  logic [2*HALF_W-1:0]    prod;
  logic [1:0]             prod_pair;
  logic [2*KEY_W-1:0]     acc;
  logic [HALF_W-1:0]      op_a;
  logic [HALF_W-1:0]      op_b;
  logic [2*HALF_W-1:0]    mul_out;
  logic [2*KEY_W-1:0]     addend;
  logic [KEY_W-1:0]       fold;
  logic                   accept;

  assign accept = request.valid && request.ready;

  // pair 0: a0*b0, 1: a0*b1, 2: a1*b0, 3: a1*b1
  assign op_a    = cnt[1] ? a[KEY_W-1:HALF_W] : a[HALF_W-1:0];
  assign op_b    = cnt[0] ? HASH_MUL_CONST[KEY_W-1:HALF_W] : HASH_MUL_CONST[HALF_W-1:0];
  assign mul_out = op_a * op_b;

  always_comb begin
    case (prod_pair)
      2'd0:    addend = {{KEY_W{1'b0}}, prod};
      2'd3:    addend = {prod, {KEY_W{1'b0}}};
      default: addend = {{HALF_W{1'b0}}, prod, {HALF_W{1'b0}}};
    endcase
  end

  assign fold = acc[KEY_W-1:0] ^ acc[2*KEY_W-1:KEY_W];

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          state_next = F_HASH;
        end
      end
      F_HASH: begin
        if (cnt == 3'd4) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    request.ready  = (state == F_IDLE) && !clearing;
    push           = (state == F_PUSH) && !full;
    push_data.mode = mode_r;
    push_data.h1   = fold[HALF_W-1:0];
    push_data.h2   = fold[KEY_W-1:HALF_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= 3'd0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= 3'd0;
      end else if (state == F_HASH) begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a      <= request.key ^ HASH_XOR_CONST;
      mode_r <= request.mode;
      acc    <= '0;
    end else if (state == F_HASH) begin
      if (!cnt[2]) begin
        prod      <= mul_out;
        prod_pair <= cnt[1:0];
      end
      if (cnt != 3'd0) begin
        acc <= acc + addend;
      end
    end
  end

endmodule

// ----- hw/rtl/bfik_queue.sv -----
// ----------------------------------------------------------------------------
// bfik_queue: hashed request queue
// Short FIFO between the hashing front and the probing back.
// ----------------------------------------------------------------------------
module bfik_queue import bfik_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  hash_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output hash_entry_t pop_data,
  output logic        empty
);

  hash_entry_t            entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full     = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/bfik_back.sv -----
// ----------------------------------------------------------------------------
// bfik_back: bit store probing and result delivery
// Clears the bit store after reset, then walks the probes of each queued
// request (read-modify-write on insert, read on test), registers the result.
// ----------------------------------------------------------------------------
module bfik_back import bfik_pkg::*; #(
  parameter int LOG2_MAX_BITS = LOG2_MAX_BITS_DEF,
  parameter int MAX_HASHES    = MAX_HASHES_DEF,
  parameter int ADDR_W        = LOG2_MAX_BITS_DEF - BIT_SEL_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 empty,
  output logic                 pop,
  input  hash_entry_t          pop_data,
  output logic                 clearing,
  output logic                 ram_we,
  output logic [ADDR_W-1:0]    ram_waddr,
  output logic [WORD_BITS-1:0] ram_wdata,
  output logic                 ram_re,
  output logic [ADDR_W-1:0]    ram_raddr,
  input  logic [WORD_BITS-1:0] ram_rdata,
  bfik_rsp_if.source           result
);

  localparam int PCNT_W = $clog2(MAX_HASHES + 1);
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int IDX_W  = LOG2_MAX_BITS;

  back_state_t          state;
  back_state_t          state_next;
  logic [ADDR_W-1:0]    clr_addr;
  logic                 mode_r;
  logic [HALF_W-1:0]    acc_idx;
  logic [HALF_W-1:0]    h2_r;
  logic [PCNT_W-1:0]    probe_cnt;
  logic [PCNT_W-1:0]    probes_r;
  logic [IDX_W-1:0]     mask_r;
  logic                 present_r;
  logic [COUNT_W-1:0]   total;
  logic [COUNT_W-1:0]   total_next;
  logic                 out_valid;
  logic                 out_present;
  logic [COUNT_W-1:0]   out_total;

  logic [PCNT_W-1:0]    probes_c;
  logic [CFG_W-1:0]     lg_c;
  logic [IDX_W-1:0]     mask_c;
  logic [IDX_W-1:0]     idx;
  logic [31:0]          idx_ext;
  logic [ADDR_W-1:0]    word_addr;
  logic [BIT_SEL_W-1:0] bit_pos;
  logic                 bit_set;
  logic                 last;
  logic                 load_out;

  // probe count and filter size limits
  always_comb begin
    if (cfg.num_hashes == '0) begin
      probes_c = PCNT_W'(1);
    end else if (32'(cfg.num_hashes) > MAX_HASHES) begin
      probes_c = PCNT_W'(MAX_HASHES);
    end else begin
      probes_c = PCNT_W'(cfg.num_hashes);
    end
    if (32'(cfg.log2_bits_used) > LOG2_MAX_BITS) begin
      lg_c = CFG_W'(LOG2_MAX_BITS);
    end else begin
      lg_c = cfg.log2_bits_used;
    end
    mask_c = ~({IDX_W{1'b1}} << lg_c);
  end

  assign idx       = acc_idx[IDX_W-1:0] & mask_r;
  assign idx_ext   = 32'(idx);
  assign word_addr = idx_ext[BIT_SEL_W +: ADDR_W];
  assign bit_pos   = idx[BIT_SEL_W-1:0];
  assign bit_set   = ram_rdata[bit_pos];
  assign last      = (probe_cnt == probes_r - 1'b1);
  assign load_out  = (state == B_DONE) && (!out_valid || result.ready);

  always_comb begin
    if ((mode_r == MODE_INSERT) && (total != '1)) begin
      total_next = total + 1'b1;
    end else begin
      total_next = total;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty) begin
          state_next = B_READ;
        end
      end
      B_READ: state_next = B_CHECK;
      B_CHECK: begin
        if (last || ((mode_r == MODE_TEST) && !bit_set)) begin
          state_next = B_DONE;
        end else begin
          state_next = B_READ;
        end
      end
      B_DONE: begin
        if (!out_valid || result.ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    clearing  = (state == B_CLEAR);
    pop       = (state == B_IDLE) && !empty;
    ram_re    = (state == B_READ);
    ram_raddr = word_addr;
    ram_we    = clearing || ((state == B_CHECK) && (mode_r == MODE_INSERT));
    ram_waddr = clearing ? clr_addr : word_addr;
    if (clearing) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_pos);
    end
    result.valid          = out_valid;
    result.present        = out_present;
    result.inserted_total = out_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      total     <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        total     <= total_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mode_r    <= pop_data.mode;
      acc_idx   <= pop_data.h1;
      h2_r      <= pop_data.h2;
      probe_cnt <= '0;
      probes_r  <= probes_c;
      mask_r    <= mask_c;
      present_r <= 1'b1;
    end else if (state == B_CHECK) begin
      acc_idx   <= acc_idx + h2_r;
      probe_cnt <= probe_cnt + 1'b1;
      if ((mode_r == MODE_TEST) && !bit_set) begin
        present_r <= 1'b0;
      end
    end
    if (load_out) begin
      out_present <= (mode_r == MODE_TEST) && present_r;
      out_total   <= total_next;
    end
  end

endmodule

// ----- hw/rtl/bloom_filter_int_keys.sv -----
// ----------------------------------------------------------------------------
// bloom_filter_int_keys: bloom filter over 64-bit keys
// Insert or test 64-bit keys against a bit store with double hashing.
// ----------------------------------------------------------------------------
// After reset the block clears its bit store, one 32-bit word a cycle, over
// all 2^(LOG2_MAX_BITS-5) words (2048 at the default size) and takes no
// request meanwhile; configuration writes are taken at any time. The front
// hashes a key in steps: intake, four partial products through one 32x32
// multiplier with accumulate, and the push into a two-entry queue. The back
// handles each probe of a request as a read of the bit store, whose read
// data is registered, then a check that writes the bit back on insert; a
// test stops at the first clear bit. Front and back overlap through the
// queue. The reset setting is 3 probes.
module bloom_filter_int_keys import bfik_pkg::*; #(
  parameter int LOG2_MAX_BITS = LOG2_MAX_BITS_DEF,
  parameter int MAX_HASHES    = MAX_HASHES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bfik_req_if.sink             request,
  bfik_rsp_if.source           result
);

  localparam int ADDR_W = (LOG2_MAX_BITS - BIT_SEL_W > 1) ? LOG2_MAX_BITS - BIT_SEL_W : 1;
  localparam int DEPTH  = 1 << ADDR_W;

  cfg_t                 cfg;
  logic                 clearing;
  logic                 push;
  hash_entry_t          push_data;
  logic                 full;
  logic                 pop;
  hash_entry_t          pop_data;
  logic                 empty;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_hashes     <= NUM_HASHES_RST;
      cfg.log2_bits_used <= LOG2_BITS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NUM_HASHES: cfg.num_hashes     <= cfg_data;
        CFG_LOG2_BITS:  cfg.log2_bits_used <= cfg_data;
        default: ;
      endcase
    end
  end

  bfik_front u_front (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .request   (request),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  bfik_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  bfik_back #(
    .LOG2_MAX_BITS (LOG2_MAX_BITS),
    .MAX_HASHES    (MAX_HASHES),
    .ADDR_W        (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .empty     (empty),
    .pop       (pop),
    .pop_data  (pop_data),
    .clearing  (clearing),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .result    (result)
  );

  bfik_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
